// File: rtl/kpst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpst_pkg
// Shared constants, types and helper functions for the key pair set table:
// field widths, action and status codes, the cell control bundle and the
// small bit-counting helpers used by the cell chain and the count unit.
// ----------------------------------------------------------------------------
package kpst_pkg;

  // Table size and derived widths.
  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths of the command and response items.
  localparam int ACT_W       = 2;
  localparam int PRE_W       = 10;
  localparam int SUF_W       = 14;
  localparam int KEY_W       = PRE_W + SUF_W;
  localparam int STAT_W      = 3;
  localparam int FIELD_CNT_W = 7;

  // The prefix count unit walks the hit vector in groups of this many cells.
  localparam int GRP_W  = 8;
  localparam int NGRP   = (CAPACITY + GRP_W - 1) / GRP_W;
  localparam int PAD_W  = NGRP * GRP_W;
  localparam int GIDX_W = (NGRP > 1) ? $clog2(NGRP) : 1;

  // Action codes; the unused code behaves as a look up.
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STAT_W-1:0] ST_REMOVED   = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND  = 3'd3;
  localparam logic [STAT_W-1:0] ST_FOUND     = 3'd4;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd5;

  // Control broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic             insert;  // append the key at the tail cell
    logic             remove;  // close the gap left by the matching cell
    logic [KEY_W-1:0] key;     // command key, {prefix, suffix}
  } cell_ctrl_t;

  // Number of set bits in one group of cells.
  function automatic logic [3:0] ones8(input logic [GRP_W-1:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < GRP_W; i++) begin
      n = n + {3'd0, v[i]};
    end
    return n;
  endfunction

  // Bit i of the result is set when any bit at or below i is set.
  function automatic logic [CAPACITY-1:0] prefix_or(input logic [CAPACITY-1:0] v);
    logic [CAPACITY-1:0] r;
    r = v;
    for (int d = 1; d < CAPACITY; d = d * 2) begin
      r = r | (r << d);
    end
    return r;
  endfunction

endpackage

// File: rtl/kpst_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpst_cell
// One slot of the table. Valid slots are kept packed at the low end of the
// chain: an insert lands in the first empty cell above a valid neighbour, and
// a removal shifts every cell at or above the removed one down by one place.
// ----------------------------------------------------------------------------
module kpst_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  kpst_pkg::cell_ctrl_t       ctrl,
  input  logic                       shift,
  input  logic                       below_valid,
  input  logic                       above_valid,
  input  logic [kpst_pkg::KEY_W-1:0] above_key,
  output logic                       valid,
  output logic [kpst_pkg::KEY_W-1:0] key,
  output logic                       key_hit,
  output logic                       prefix_hit
);

  logic tail;

  // This cell is the tail when it is empty and the cell below is occupied.
  assign tail = below_valid && !valid;

  // Valid mark: cleared at reset, set on insert, taken from above on removal.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.insert && tail) begin
      valid <= 1'b1;
    end else if (ctrl.remove && shift) begin
      valid <= above_valid;
    end
  end

  // Key storage needs no reset; it is only looked at while valid.
  always_ff @(posedge clk) begin
    if (ctrl.insert && tail) begin
      key <= ctrl.key;
    end else if (ctrl.remove && shift) begin
      key <= above_key;
    end
  end

  // Compare the stored key against the command.
  assign key_hit    = valid && (key == ctrl.key);
  assign prefix_hit = valid && (key[kpst_pkg::KEY_W-1 -: kpst_pkg::PRE_W] ==
                                ctrl.key[kpst_pkg::KEY_W-1 -: kpst_pkg::PRE_W]);

endmodule

// File: rtl/kpst_count.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpst_count
// Serial population count of the prefix hit vector. The vector is loaded on
// start and one group of cells is added to the running sum each cycle; done
// pulses for one cycle once the sum is complete.
// ----------------------------------------------------------------------------
module kpst_count (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [kpst_pkg::PAD_W-1:0]  hits,
  output logic                        done,
  output logic [kpst_pkg::CNT_W-1:0]  total
);

  logic                        run;
  logic [kpst_pkg::GIDX_W-1:0] grp;
  logic [kpst_pkg::PAD_W-1:0]  vec;
  logic                        last;

  assign last = (grp == kpst_pkg::GIDX_W'(kpst_pkg::NGRP - 1));

  // Control: run flag, group counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      grp  <= '0;
      done <= 1'b0;
    end else begin
      done <= run && last;
      if (start) begin
        run <= 1'b1;
        grp <= '0;
      end else if (run) begin
        grp <= grp + 1'b1;
        if (last) begin
          run <= 1'b0;
        end
      end
    end
  end

  // Datapath: shift the vector down one group a cycle and accumulate.
  always_ff @(posedge clk) begin
    if (start) begin
      vec   <= hits;
      total <= '0;
    end else if (run) begin
      vec   <= vec >> kpst_pkg::GRP_W;
      total <= total + kpst_pkg::CNT_W'(kpst_pkg::ones8(vec[kpst_pkg::GRP_W-1:0]));
    end
  end

endmodule

// File: rtl/key_pair_set_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_pair_set_table
// A set of up to CAPACITY (prefix, suffix) pairs held in a chain of cells.
//
// Commands arrive on the cmd channel (action, prefix, suffix) and each one
// gives exactly one item on the rsp channel (status, prefix_count,
// entry_count, is_empty), in command order. An item is taken on a channel
// when its valid is high and its stall is low.
// One command is worked on at a time: it is compared in the cells, the
// prefix count unit adds up one group of eight cells per cycle, and the
// final step updates the table and registers the response. cmd_stall is low
// again as soon as the response is registered, so the next command can be
// accepted while that response still waits.
// If the receiver stalls, the finished command waits in its final step and
// the table is not updated until the response register is free.
// Reset empties the table at once: every valid mark and the entry count are
// cleared in the reset cycle, and no clearing pass follows.
// ----------------------------------------------------------------------------
module key_pair_set_table (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_stall,
  input  logic [kpst_pkg::ACT_W-1:0]        action,
  input  logic [kpst_pkg::PRE_W-1:0]        prefix,
  input  logic [kpst_pkg::SUF_W-1:0]        suffix,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic [kpst_pkg::STAT_W-1:0]       status,
  output logic [kpst_pkg::FIELD_CNT_W-1:0]  prefix_count,
  output logic [kpst_pkg::FIELD_CNT_W-1:0]  entry_count,
  output logic                              is_empty
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CMP   = 2'd1;
  localparam logic [1:0] S_SUM   = 2'd2;
  localparam logic [1:0] S_APPLY = 2'd3;

  logic [1:0]                     state;
  logic [1:0]                     state_next;
  logic [kpst_pkg::ACT_W-1:0]     act;
  logic [kpst_pkg::KEY_W-1:0]     cmd_key;
  logic [kpst_pkg::CNT_W-1:0]     count;
  logic [kpst_pkg::CNT_W-1:0]     count_next;
  logic [kpst_pkg::CNT_W-1:0]     pcount_next;
  logic [kpst_pkg::STAT_W-1:0]    status_next;
  logic [kpst_pkg::CAPACITY-1:0]  hit_q;
  logic [kpst_pkg::CAPACITY-1:0]  shift_vec;
  logic [kpst_pkg::CAPACITY-1:0]  valid_vec;
  logic [kpst_pkg::CAPACITY-1:0]  key_hit_vec;
  logic [kpst_pkg::CAPACITY-1:0]  pre_hit_vec;
  logic [kpst_pkg::KEY_W-1:0]     key_arr [kpst_pkg::CAPACITY];
  logic                           any_hit;
  logic                           full;
  logic                           apply_go;
  logic                           cnt_done;
  logic [kpst_pkg::CNT_W-1:0]     cnt_total;
  kpst_pkg::cell_ctrl_t           ctrl;

  // Only one command is held at a time.
  assign cmd_stall = (state != S_IDLE);

  // The update and response happen once the response register is free.
  assign apply_go = (state == S_APPLY) && (!rsp_valid || !rsp_stall);

  assign any_hit   = |hit_q;
  assign full      = (count == kpst_pkg::CNT_W'(kpst_pkg::CAPACITY));
  assign shift_vec = kpst_pkg::prefix_or(hit_q);

  // Control broadcast to the cells.
  always_comb begin
    ctrl.key    = cmd_key;
    ctrl.insert = apply_go && (act == kpst_pkg::ACT_INSERT) && !any_hit && !full;
    ctrl.remove = apply_go && (act == kpst_pkg::ACT_REMOVE) && any_hit;
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        state_next = S_SUM;
      end
      S_SUM: begin
        if (cnt_done) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        if (apply_go) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Command register.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid) begin
      act     <= action;
      cmd_key <= {prefix, suffix};
    end
  end

  // Key match vector, captured once the cells have compared.
  always_ff @(posedge clk) begin
    if (state == S_CMP) begin
      hit_q <= key_hit_vec;
    end
  end

  // Status and the counts after the step. The inserted or removed pair
  // shares the command prefix, so it moves the prefix count by one.
  always_comb begin
    count_next  = count;
    pcount_next = cnt_total;
    priority if (act == kpst_pkg::ACT_INSERT) begin
      if (any_hit) begin
        status_next = kpst_pkg::ST_DUPLICATE;
      end else if (full) begin
        status_next = kpst_pkg::ST_FULL;
      end else begin
        status_next = kpst_pkg::ST_INSERTED;
        count_next  = count + 1'b1;
        pcount_next = cnt_total + 1'b1;
      end
    end else if (act == kpst_pkg::ACT_REMOVE) begin
      if (any_hit) begin
        status_next = kpst_pkg::ST_REMOVED;
        count_next  = count - 1'b1;
        pcount_next = cnt_total - 1'b1;
      end else begin
        status_next = kpst_pkg::ST_NOTFOUND;
      end
    end else begin
      status_next = any_hit ? kpst_pkg::ST_FOUND : kpst_pkg::ST_NOTFOUND;
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (apply_go) begin
      count <= count_next;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (apply_go) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      status       <= status_next;
      prefix_count <= kpst_pkg::FIELD_CNT_W'(pcount_next);
      entry_count  <= kpst_pkg::FIELD_CNT_W'(count_next);
      is_empty     <= (count_next == '0);
    end
  end

  // Chain of cells; each takes its neighbour's contents on removal.
  for (genvar i = 0; i < kpst_pkg::CAPACITY; i++) begin : g_cell
    logic                       below_v;
    logic                       above_v;
    logic [kpst_pkg::KEY_W-1:0] above_k;

    if (i == 0) begin : g_first
      assign below_v = 1'b1;
    end else begin : g_inner_lo
      assign below_v = valid_vec[i-1];
    end

    if (i == kpst_pkg::CAPACITY - 1) begin : g_last
      assign above_v = 1'b0;
      assign above_k = '0;
    end else begin : g_inner_hi
      assign above_v = valid_vec[i+1];
      assign above_k = key_arr[i+1];
    end

    kpst_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .shift      (shift_vec[i]),
      .below_valid(below_v),
      .above_valid(above_v),
      .above_key  (above_k),
      .valid      (valid_vec[i]),
      .key        (key_arr[i]),
      .key_hit    (key_hit_vec[i]),
      .prefix_hit (pre_hit_vec[i])
    );
  end

  // Prefix count over the chain, one group of cells a cycle.
  kpst_count u_count (
    .clk  (clk),
    .rst  (rst),
    .start(state == S_CMP),
    .hits (kpst_pkg::PAD_W'(pre_hit_vec)),
    .done (cnt_done),
    .total(cnt_total)
  );

  // The entry count always agrees with the number of valid cells.
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    count == kpst_pkg::CNT_W'($countones(valid_vec)))
    else $error("entry count differs from number of valid cells");

  // Valid cells stay packed at the low end of the chain.
  a_packed: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("valid cells are not contiguous");

  // A key is never stored twice, so at most one cell matches.
  a_unique_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY) |-> $onehot0(hit_q))
    else $error("more than one cell matches the command key");

  // A response is loaded only from the final step of a command.
  a_rsp_from_apply: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_APPLY))
    else $error("response raised outside the final step");

endmodule

// File: test/key_pair_set_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_pair_set_table_test
// Self-checking bench for the key pair set table. A short directed table
// covers the empty table, duplicates, the spare action code and the widest
// field values. It is followed by random commands in fill, drain and mixed
// phases, so the table runs full and empty again many times. A behavioural
// copy of the table predicts every response that the directed table does not
// give itself, and both channels idle at random.
// ----------------------------------------------------------------------------
module key_pair_set_table_test;

  // The action code that the block treats as a look up.
  localparam logic [kpst_pkg::ACT_W-1:0] ACT_SPARE = 2'd3;

  localparam int RANDOM_ITEMS   = 1350;
  localparam int PHASE_ITEMS    = 90;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic [kpst_pkg::STAT_W-1:0]      status;
    logic [kpst_pkg::FIELD_CNT_W-1:0] prefix_count;
    logic [kpst_pkg::FIELD_CNT_W-1:0] entry_count;
    logic                             is_empty;
  } set_resp_t;

  typedef struct packed {
    logic [kpst_pkg::ACT_W-1:0] act;
    logic [kpst_pkg::PRE_W-1:0] pre;
    logic [kpst_pkg::SUF_W-1:0] suf;
    logic                       typed;
    set_resp_t                  want;
  } cmd_row_t;

  localparam set_resp_t NONE = '0;

  // Directed commands; rows with the typed mark carry their own response.
  localparam int PLAN_LEN = 24;
  localparam cmd_row_t PLAN [PLAN_LEN] = '{
    '{kpst_pkg::ACT_LOOKUP, 10'd0,    14'd0,     1'b1,
      '{kpst_pkg::ST_NOTFOUND,  7'd0, 7'd0, 1'b1}},
    '{kpst_pkg::ACT_REMOVE, 10'd0,    14'd0,     1'b1,
      '{kpst_pkg::ST_NOTFOUND,  7'd0, 7'd0, 1'b1}},
    '{kpst_pkg::ACT_INSERT, 10'd0,    14'd0,     1'b1,
      '{kpst_pkg::ST_INSERTED,  7'd1, 7'd1, 1'b0}},
    '{kpst_pkg::ACT_INSERT, 10'd0,    14'd0,     1'b1,
      '{kpst_pkg::ST_DUPLICATE, 7'd1, 7'd1, 1'b0}},
    '{kpst_pkg::ACT_INSERT, 10'd1023, 14'd16383, 1'b1,
      '{kpst_pkg::ST_INSERTED,  7'd1, 7'd2, 1'b0}},
    '{kpst_pkg::ACT_LOOKUP, 10'd1023, 14'd16383, 1'b1,
      '{kpst_pkg::ST_FOUND,     7'd1, 7'd2, 1'b0}},
    '{ACT_SPARE,            10'd0,    14'd0,     1'b1,
      '{kpst_pkg::ST_FOUND,     7'd1, 7'd2, 1'b0}},
    '{ACT_SPARE,            10'd1023, 14'd0,     1'b1,
      '{kpst_pkg::ST_NOTFOUND,  7'd1, 7'd2, 1'b0}},
    '{kpst_pkg::ACT_INSERT, 10'd999,  14'd9999,  1'b0, NONE},
    '{kpst_pkg::ACT_INSERT, 10'd999,  14'd0,     1'b0, NONE},
    '{kpst_pkg::ACT_INSERT, 10'd999,  14'd1,     1'b0, NONE},
    '{kpst_pkg::ACT_LOOKUP, 10'd999,  14'd5,     1'b0, NONE},
    '{kpst_pkg::ACT_REMOVE, 10'd999,  14'd0,     1'b0, NONE},
    '{kpst_pkg::ACT_REMOVE, 10'd999,  14'd0,     1'b0, NONE},
    '{kpst_pkg::ACT_INSERT, 10'd682,  14'd10922, 1'b0, NONE},
    '{kpst_pkg::ACT_INSERT, 10'd341,  14'd5461,  1'b0, NONE},
    '{kpst_pkg::ACT_LOOKUP, 10'd341,  14'd10922, 1'b0, NONE},
    '{kpst_pkg::ACT_REMOVE, 10'd0,    14'd0,     1'b0, NONE},
    '{kpst_pkg::ACT_REMOVE, 10'd1023, 14'd16383, 1'b0, NONE},
    '{kpst_pkg::ACT_REMOVE, 10'd999,  14'd9999,  1'b0, NONE},
    '{kpst_pkg::ACT_REMOVE, 10'd999,  14'd1,     1'b0, NONE},
    '{kpst_pkg::ACT_REMOVE, 10'd682,  14'd10922, 1'b0, NONE},
    '{kpst_pkg::ACT_REMOVE, 10'd341,  14'd5461,  1'b0, NONE},
    '{kpst_pkg::ACT_LOOKUP, 10'd341,  14'd5461,  1'b1,
      '{kpst_pkg::ST_NOTFOUND,  7'd0, 7'd0, 1'b1}}
  };

  // Prefixes shared by many random pairs, so that prefix counts grow.
  localparam logic [kpst_pkg::PRE_W-1:0] BUSY_PREFIX [4] =
    '{10'd0, 10'd512, 10'd999, 10'd1023};

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cmd_valid = 1'b0;
  logic                             cmd_stall;
  logic [kpst_pkg::ACT_W-1:0]       action = '0;
  logic [kpst_pkg::PRE_W-1:0]       prefix = '0;
  logic [kpst_pkg::SUF_W-1:0]       suffix = '0;
  logic                             rsp_valid;
  logic                             rsp_stall = 1'b0;
  logic [kpst_pkg::STAT_W-1:0]      status;
  logic [kpst_pkg::FIELD_CNT_W-1:0] prefix_count;
  logic [kpst_pkg::FIELD_CNT_W-1:0] entry_count;
  logic                             is_empty;

  // Behavioural copy of the table.
  logic [kpst_pkg::KEY_W-1:0] slot_key  [kpst_pkg::CAPACITY];
  bit                         slot_used [kpst_pkg::CAPACITY];
  int unsigned                pair_total = 0;

  cmd_row_t  offered_q [$];
  set_resp_t expected_rsp_q [$];
  int unsigned cmd_total   = 0;
  int unsigned rsp_total   = 0;
  int unsigned fault_count = 0;
  int unsigned quiet_count = 0;
  bit          no_idle     = 1'b0;

  key_pair_set_table i_dut (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .action       (action),
    .prefix       (prefix),
    .suffix       (suffix),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .status       (status),
    .prefix_count (prefix_count),
    .entry_count  (entry_count),
    .is_empty     (is_empty)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Applies one command to the table copy and returns the response it gives.
  function automatic set_resp_t apply_command(input logic [kpst_pkg::ACT_W-1:0] act,
                                              input logic [kpst_pkg::PRE_W-1:0] pre,
                                              input logic [kpst_pkg::SUF_W-1:0] suf);
    logic [kpst_pkg::KEY_W-1:0] key;
    int                         hit;
    int                         free;
    int unsigned                same;
    set_resp_t                  r;
    key  = {pre, suf};
    hit  = -1;
    free = -1;
    same = 0;
    for (int i = 0; i < kpst_pkg::CAPACITY; i++) begin
      if (slot_used[i] && slot_key[i] == key && hit < 0) hit = i;
      if (!slot_used[i] && free < 0) free = i;
    end
    case (act)
      kpst_pkg::ACT_INSERT: begin
        if (hit >= 0) begin
          r.status = kpst_pkg::ST_DUPLICATE;
        end else if (free >= 0) begin
          slot_key[free]  = key;
          slot_used[free] = 1'b1;
          pair_total++;
          r.status = kpst_pkg::ST_INSERTED;
        end else begin
          r.status = kpst_pkg::ST_FULL;
        end
      end
      kpst_pkg::ACT_REMOVE: begin
        if (hit >= 0) begin
          slot_used[hit] = 1'b0;
          pair_total--;
          r.status = kpst_pkg::ST_REMOVED;
        end else begin
          r.status = kpst_pkg::ST_NOTFOUND;
        end
      end
      default: begin
        r.status = (hit >= 0) ? kpst_pkg::ST_FOUND : kpst_pkg::ST_NOTFOUND;
      end
    endcase
    for (int i = 0; i < kpst_pkg::CAPACITY; i++) begin
      if (slot_used[i] && slot_key[i][kpst_pkg::KEY_W-1:kpst_pkg::SUF_W] == pre) same++;
    end
    r.prefix_count = kpst_pkg::FIELD_CNT_W'(same);
    r.entry_count  = kpst_pkg::FIELD_CNT_W'(pair_total);
    r.is_empty     = (pair_total == 0);
    return r;
  endfunction

  // Idle cycles before the next item on either side.
  function automatic int idle_draw();
    if (no_idle || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  // Offers one command and returns at the edge where it is accepted.
  task automatic send_command(input cmd_row_t row);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    offered_q.push_back(row);
    cmd_valid <= 1'b1;
    action    <= row.act;
    prefix    <= row.pre;
    suffix    <= row.suf;
    do @(posedge clk); while (cmd_stall);
    cmd_total++;
  endtask

  // Command side: directed table, then random phases, then the final wait.
  initial begin
    cmd_row_t    row;
    int unsigned mode;
    int unsigned pick;
    int unsigned start;
    bit          taken;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int n = 0; n < PLAN_LEN; n++) begin
      send_command(PLAN[n]);
    end

    mode = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Fill, mixed and drain phases in turn; some phases run without idling.
      if (n % PHASE_ITEMS == 0) begin
        mode    = (n / PHASE_ITEMS) % 3;
        no_idle = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      case (mode)
        0:       row.act = (pick < 80) ? kpst_pkg::ACT_INSERT :
                           (pick < 88) ? kpst_pkg::ACT_LOOKUP :
                           (pick < 95) ? kpst_pkg::ACT_REMOVE : ACT_SPARE;
        1:       row.act = (pick < 35) ? kpst_pkg::ACT_INSERT :
                           (pick < 65) ? kpst_pkg::ACT_REMOVE :
                           (pick < 92) ? kpst_pkg::ACT_LOOKUP : ACT_SPARE;
        default: row.act = (pick < 75) ? kpst_pkg::ACT_REMOVE :
                           (pick < 85) ? kpst_pkg::ACT_INSERT :
                           (pick < 95) ? kpst_pkg::ACT_LOOKUP : ACT_SPARE;
      endcase

      // Pairs come from the stored set, from a small busy pool or from anywhere.
      pick  = $urandom_range(0, 99);
      taken = 1'b0;
      if (pick < 45) begin
        start = $urandom_range(0, kpst_pkg::CAPACITY - 1);
        for (int j = 0; j < kpst_pkg::CAPACITY; j++) begin
          if (!taken && slot_used[(start + j) % kpst_pkg::CAPACITY]) begin
            {row.pre, row.suf} = slot_key[(start + j) % kpst_pkg::CAPACITY];
            taken = 1'b1;
          end
        end
      end
      if (!taken) begin
        if (pick < 85) begin
          row.pre = BUSY_PREFIX[$urandom_range(0, 3)];
          row.suf = kpst_pkg::SUF_W'($urandom_range(0, 39));
        end else begin
          row.pre = kpst_pkg::PRE_W'($urandom_range(0, 1023));
          row.suf = kpst_pkg::SUF_W'($urandom_range(0, 16383));
        end
      end
      row.typed = 1'b0;
      row.want  = NONE;
      send_command(row);
    end
    cmd_valid <= 1'b0;
    no_idle   = 1'b0;

    while (rsp_total != cmd_total) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_rsp_q.size() != 0) begin
      $error("%0d responses never arrived", expected_rsp_q.size());
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Response side: stall for a drawn number of cycles once an item is offered.
  initial begin
    int hold;
    forever begin
      hold = idle_draw();
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        do @(posedge clk); while (!rsp_valid);
        repeat (hold - 1) @(posedge clk);
        rsp_stall <= 1'b0;
      end
      do @(posedge clk); while (!rsp_valid);
    end
  end

  // Predicts on each accepted command and checks each accepted response.
  always @(posedge clk) begin : monitor
    cmd_row_t  row;
    set_resp_t want;
    bit        moved;
    if (!rst) begin
      moved = 1'b0;
      if (cmd_valid && !cmd_stall) begin
        moved = 1'b1;
        row   = offered_q.pop_front();
        want  = apply_command(action, prefix, suffix);
        if (row.typed) want = row.want;
        expected_rsp_q.push_back(want);
      end
      if (rsp_valid && !rsp_stall) begin
        moved = 1'b1;
        rsp_total++;
        if (expected_rsp_q.size() == 0) begin
          $error("response item with no command waiting");
          fault_count++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            fault_count++;
          end
          if (prefix_count !== want.prefix_count) begin
            $error("prefix_count: expected %0d, got %0d", want.prefix_count, prefix_count);
            fault_count++;
          end
          if (entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, entry_count);
            fault_count++;
          end
          if (is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, is_empty);
            fault_count++;
          end
        end
      end
      // Watchdog on cycles in which no item moves on either side.
      quiet_count = moved ? 0 : quiet_count + 1;
      if (quiet_count == WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule
